// ===== rtl/mst_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg
// Types and constants shared by the spanning tree core and its parts.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int WEIGHT_BITS  = 16;
	localparam int VID_W        = $clog2(MAX_VERTICES);
	localparam int ADDR_W       = 2 * VID_W;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int TOTAL_W      = 20;
	localparam int QDEPTH       = 2;
	localparam int QPTR_W       = $clog2(QDEPTH);

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_SOLVE = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SOLVE,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [VID_W-1:0]       from_vertex;
		logic [VID_W-1:0]       to_vertex;
		logic [WEIGHT_BITS-1:0] weight;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} qctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_FINAL
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/mst_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mst channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface mst_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] from_vertex;
	logic [3:0] to_vertex;
	logic [15:0] weight;
	modport source (output valid, kind, from_vertex, to_vertex, weight, input ready);
	modport sink (input valid, kind, from_vertex, to_vertex, weight, output ready);
endinterface

interface mst_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  parent_vertex;
	logic [3:0]  child_vertex;
	logic [15:0] edge_cost;
	logic [19:0] total_cost;
	logic        status;
	logic        last;
	modport source (output valid, parent_vertex, child_vertex, edge_cost, total_cost,
		status, last, input ready);
	modport sink (input valid, parent_vertex, child_vertex, edge_cost, total_cost,
		status, last, output ready);
endinterface

interface mst_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] vertex_count;
	modport source (output valid, vertex_count, input ready);
	modport sink (input valid, vertex_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/minimum_spanning_tree_prim_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// minimum_spanning_tree_prim_core
// Prim spanning tree engine over a 16 by 16 adjacency store.
// ----------------------------------------------------------------------------
// Load and clear beats are queued and dropped beats are discarded; beats are
// accepted back to back while the two-entry command queue has room. A solve of
// n vertices reads the single-port weight memory once per vertex pair in each
// round; result beats wait in an output register while later commands queue up.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_prim_core (
	input  wire logic clk,
	input  wire logic arst_n,
	mst_in_if.sink    in_ch,
	mst_out_if.source out_ch,
	mst_cfg_if.sink   cfg
);

	mst_pkg::cmd_t                 cmd;
	mst_pkg::qctl_t                front_ctl;
	mst_pkg::qctl_t                back_ctl;
	logic [4:0]                    vertex_count_q;
	logic [mst_pkg::CNT_W-1:0]     n_active;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= 5'd1;
		end else if (cfg.valid) begin
			vertex_count_q <= cfg.vertex_count;
		end
	end

	always_comb begin
		if (vertex_count_q == 5'd0) begin
			n_active = mst_pkg::CNT_W'(1);
		end else if (32'(vertex_count_q) > mst_pkg::MAX_VERTICES) begin
			n_active = mst_pkg::CNT_W'(mst_pkg::MAX_VERTICES);
		end else begin
			n_active = mst_pkg::CNT_W'(vertex_count_q);
		end
	end

	mst_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.cmd     (cmd),
		.ctl_in  (back_ctl),
		.ctl_out (front_ctl)
	);

	mst_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.n_active (n_active),
		.cmd      (cmd),
		.ctl_in   (front_ctl),
		.ctl_out  (back_ctl),
		.out_ch   (out_ch)
	);

endmodule
`default_nettype wire

// ===== rtl/mst_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mst_front
// Accepts input beats, decodes them into commands and queues those it keeps.
// ----------------------------------------------------------------------------
module mst_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	mst_in_if.sink                in_ch,
	output mst_pkg::cmd_t         cmd,
	input  wire mst_pkg::qctl_t   ctl_in,
	output mst_pkg::qctl_t        ctl_out
);

	mst_pkg::cmd_t                 q_mem [mst_pkg::QDEPTH];
	logic [mst_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [mst_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [mst_pkg::QPTR_W:0]      count_q;
	logic                          full;
	logic                          keep;
	logic                          push;
	logic                          pop;
	mst_pkg::cmd_t                 dec;

	assign full = (count_q == (mst_pkg::QPTR_W+1)'(mst_pkg::QDEPTH));
	assign in_ch.ready = !full;

	always_comb begin
		dec.from_vertex = in_ch.from_vertex;
		dec.to_vertex   = in_ch.to_vertex;
		dec.weight      = in_ch.weight;
		dec.op          = mst_pkg::OP_LOAD;
		keep            = 1'b0;
		unique case (in_ch.kind)
			mst_pkg::KIND_LOAD: begin
				dec.op = mst_pkg::OP_LOAD;
				keep   = (32'(in_ch.from_vertex) < mst_pkg::MAX_VERTICES) &&
					(32'(in_ch.to_vertex) < mst_pkg::MAX_VERTICES);
			end
			mst_pkg::KIND_SOLVE: begin
				dec.op = mst_pkg::OP_SOLVE;
				keep   = 1'b1;
			end
			mst_pkg::KIND_CLEAR: begin
				dec.op = mst_pkg::OP_CLEAR;
				keep   = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = in_ch.valid && !full && keep;
	assign pop  = ctl_in.pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign cmd           = q_mem[rd_ptr_q];
	assign ctl_out.valid = (count_q != '0);
	assign ctl_out.pop   = pop;

endmodule
`default_nettype wire

// ===== rtl/mst_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mst_back
// Holds the adjacency store and runs the tree search for solve commands.
// ----------------------------------------------------------------------------
module mst_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [mst_pkg::CNT_W-1:0]     n_active,
	input  wire mst_pkg::cmd_t                 cmd,
	input  wire mst_pkg::qctl_t                ctl_in,
	output mst_pkg::qctl_t                     ctl_out,
	mst_out_if.source                          out_ch
);

	localparam int NE = mst_pkg::MAX_VERTICES * mst_pkg::MAX_VERTICES;
	localparam int VW = mst_pkg::VID_W;
	localparam int WB = mst_pkg::WEIGHT_BITS;
	localparam int TW = mst_pkg::TOTAL_W;

	logic [WB-1:0]                   cost_mem [NE];
	logic [NE-1:0]                   present_q;
	logic [mst_pkg::MAX_VERTICES-1:0] visited_q;
	mst_pkg::state_t                 state_q, state_d;

	logic [VW-1:0]                   u_q, v_q;
	logic [mst_pkg::CNT_W-1:0]       count_q;
	logic [TW-1:0]                   total_q;
	logic                            status_q;
	logic                            found_q;
	logic [WB-1:0]                   best_q;
	logic [VW-1:0]                   bp_q, bc_q;

	logic                            qual_s1;
	logic [VW-1:0]                   u_s1, v_s1;
	logic [WB-1:0]                   rd_s1;

	logic                            out_valid_q;
	logic [VW-1:0]                   out_par_q, out_chi_q;
	logic [WB-1:0]                   out_cost_q;
	logic [TW-1:0]                   out_total_q;
	logic                            out_status_q;
	logic                            out_last_q;

	logic [VW-1:0]                   last_v;
	logic                            scan_end;
	logic                            slot_free;
	logic                            take;
	logic                            start_solve;
	logic                            issue;
	logic                            emit_edge;
	logic                            emit_final;
	logic [mst_pkg::ADDR_W-1:0]      addr;
	logic [TW:0]                     sum;

	assign last_v    = VW'(n_active - 1'b1);
	assign scan_end  = (u_q == last_v) && (v_q == last_v);
	assign slot_free = !out_valid_q || out_ch.ready;
	assign addr      = (state_q == mst_pkg::ST_SCAN) ? {u_q, v_q}
		: {cmd.from_vertex, cmd.to_vertex};
	assign sum       = {1'b0, total_q} + (TW+1)'(best_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mst_pkg::ST_IDLE: begin
				if (ctl_in.valid && cmd.op == mst_pkg::OP_SOLVE) begin
					state_d = (n_active == mst_pkg::CNT_W'(1)) ? mst_pkg::ST_FINAL
						: mst_pkg::ST_SCAN;
				end
			end
			mst_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = mst_pkg::ST_DRAIN;
				end
			end
			mst_pkg::ST_DRAIN: begin
				state_d = mst_pkg::ST_PICK;
			end
			mst_pkg::ST_PICK: begin
				if (!found_q) begin
					state_d = mst_pkg::ST_FINAL;
				end else if (slot_free) begin
					state_d = (count_q + 1'b1 == n_active) ? mst_pkg::ST_FINAL
						: mst_pkg::ST_SCAN;
				end
			end
			mst_pkg::ST_FINAL: begin
				if (slot_free) begin
					state_d = mst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mst_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		take        = (state_q == mst_pkg::ST_IDLE) && ctl_in.valid;
		start_solve = take && (cmd.op == mst_pkg::OP_SOLVE);
		issue       = (state_q == mst_pkg::ST_SCAN);
		emit_edge   = (state_q == mst_pkg::ST_PICK) && found_q && slot_free;
		emit_final  = (state_q == mst_pkg::ST_FINAL) && slot_free;
	end

	assign ctl_out.valid = 1'b0;
	assign ctl_out.pop   = take;

	always_ff @(posedge clk) begin
		if (take && cmd.op == mst_pkg::OP_LOAD) begin
			cost_mem[addr] <= cmd.weight;
		end
		rd_s1 <= cost_mem[addr];
		u_s1  <= u_q;
		v_s1  <= v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mst_pkg::ST_IDLE;
			present_q   <= '0;
			visited_q   <= '0;
			u_q         <= '0;
			v_q         <= '0;
			count_q     <= '0;
			total_q     <= '0;
			status_q    <= 1'b0;
			found_q     <= 1'b0;
			best_q      <= '0;
			bp_q        <= '0;
			bc_q        <= '0;
			qual_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			qual_s1 <= issue && visited_q[u_q] && present_q[{u_q, v_q}] && !visited_q[v_q];

			if (take && cmd.op == mst_pkg::OP_LOAD) begin
				present_q[addr] <= 1'b1;
			end
			if (take && cmd.op == mst_pkg::OP_CLEAR) begin
				present_q <= '0;
			end

			if (start_solve) begin
				visited_q    <= mst_pkg::MAX_VERTICES'(1);
				total_q      <= '0;
				status_q     <= 1'b0;
				count_q      <= mst_pkg::CNT_W'(1);
				u_q          <= '0;
				v_q          <= '0;
				found_q      <= 1'b0;
			end

			if (issue) begin
				if (v_q == last_v) begin
					v_q <= '0;
					u_q <= u_q + 1'b1;
				end else begin
					v_q <= v_q + 1'b1;
				end
			end

			if (qual_s1 && (!found_q || rd_s1 < best_q)) begin
				found_q <= 1'b1;
				best_q  <= rd_s1;
				bp_q    <= u_s1;
				bc_q    <= v_s1;
			end

			if (state_q == mst_pkg::ST_PICK && !found_q) begin
				status_q <= 1'b1;
			end

			if (emit_edge) begin
				visited_q[bc_q] <= 1'b1;
				count_q         <= count_q + 1'b1;
				total_q         <= sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
				u_q             <= '0;
				v_q             <= '0;
				found_q         <= 1'b0;
			end

			if (emit_edge || emit_final) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_edge) begin
			out_par_q    <= bp_q;
			out_chi_q    <= bc_q;
			out_cost_q   <= best_q;
			out_total_q  <= '0;
			out_status_q <= 1'b0;
			out_last_q   <= 1'b0;
		end else if (emit_final) begin
			out_par_q    <= '0;
			out_chi_q    <= '0;
			out_cost_q   <= '0;
			out_total_q  <= total_q;
			out_status_q <= status_q;
			out_last_q   <= 1'b1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.parent_vertex = out_par_q;
	assign out_ch.child_vertex  = out_chi_q;
	assign out_ch.edge_cost     = out_cost_q;
	assign out_ch.total_cost    = out_total_q;
	assign out_ch.status        = out_status_q;
	assign out_ch.last          = out_last_q;

endmodule
`default_nettype wire
